// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file of the packet framer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define XCPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never be seen at a clock edge
`define XCPF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `XCPF_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ----- design/xcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// xcpf_pkg
// Types and constants of the XOR checksum packet framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcpf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 16;
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // configuration register indexes
  localparam logic CfgStartMarker    = 1'b0;
  localparam logic CfgLengthOverhead = 1'b1;

  // configuration reset values
  localparam logic [ByteW-1:0] StartMarkerRst    = 8'h02;
  localparam logic [ByteW-1:0] LengthOverheadRst = 8'h05;

  // input item kinds
  localparam logic KindStart   = 1'b0;
  localparam logic KindPayload = 1'b1;

  // protocol error codes
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrStray   = 2'd1,
    ErrAbandon = 2'd2
  } err_e;

  // configuration register contents
  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] length_overhead;
  } cfg_t;

  // one accepted input request
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  payload_len;
    logic [ByteW-1:0] data_byte;
  } item_t;

  // all bytes that one request sends
  typedef struct packed {
    logic [MaxResults-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                  count;
    logic                             chk;
    err_e                             err;
  } burst_t;

endpackage

// ----- design/xcpf_stream_if.sv -----
// ----------------------------------------------------------------------------
// xcpf_stream_if
// Valid/ready channels of the packet framer: request side and byte side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xcpf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  command;
  logic [15:0] payload_len;
  logic [7:0]  data_byte;

  modport source (output valid, kind, command, payload_len, data_byte, input ready);
  modport sink (input valid, kind, command, payload_len, data_byte, output ready);
  modport monitor (input valid, ready, kind, command, payload_len, data_byte);
endinterface

interface xcpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_last;
  logic       is_checksum;
  logic [1:0] protocol_error;

  modport source (output valid, tx_byte, run_last, is_checksum, protocol_error,
                  input ready);
  modport sink (input valid, tx_byte, run_last, is_checksum, protocol_error,
                output ready);
  modport monitor (input valid, ready, tx_byte, run_last, is_checksum, protocol_error);
endinterface

// ----- design/xor_checksum_packet_framer.sv -----
// A request enters every cycle that the request register is free. Each
// request becomes a burst of bytes in the result register, which the byte
// port sends one per cycle while the sink is ready: a payload request gives
// one byte (two when it closes the packet with the checksum), a start request
// gives four bytes (five for an empty packet), and a stray payload byte gives
// one. The single byte-wide output port sets the rate; the request register
// lets the next request wait while a burst drains. No clearing pass after reset.
// ----------------------------------------------------------------------------
// xor_checksum_packet_framer
// Frames packets with start marker, 16-bit length, command, payload and a
// closing XOR checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checksum_packet_framer import xcpf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [ByteW-1:0] cfg_data_i,
  xcpf_in_if.sink          in_i,
  xcpf_out_if.source       out_o
);

  cfg_t   cfg;
  logic   burst_valid;
  logic   burst_ready;
  burst_t burst;

  // configuration registers
  xcpf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // request register and framing logic
  xcpf_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_i          (in_i),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready),
    .burst_o       (burst)
  );

  // result register and byte serializer
  xcpf_tx_burst u_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_valid_i (burst_valid),
    .burst_ready_o (burst_ready),
    .burst_i       (burst),
    .out_o         (out_o)
  );

endmodule

// ----- design/xcpf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// xcpf_cfg_regs
// Start marker and length overhead registers with a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcpf_cfg_regs import xcpf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [ByteW-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_d, cfg_q;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartMarker:    cfg_d.start_marker    = cfg_data_i;
        CfgLengthOverhead: cfg_d.length_overhead = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= StartMarkerRst;
      cfg_q.length_overhead <= LengthOverheadRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/xcpf_framer.sv -----
// ----------------------------------------------------------------------------
// xcpf_framer
// Input register, packet state and the logic that turns one request into
// a burst of bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcpf_framer import xcpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  xcpf_in_if.sink   in_i,
  output logic      burst_valid_o,
  input  logic      burst_ready_i,
  output burst_t    burst_o
);

  item_t            item_q;
  logic             item_valid_q, item_valid_d;
  logic             open_q, open_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [ByteW-1:0] xor_q, xor_d;

  logic             in_fire;
  logic             move;
  logic [LenW-1:0]  total;
  logic [ByteW-1:0] hdr_xor;
  logic [ByteW-1:0] data_xor;
  logic             last_byte;
  burst_t           burst;

  // request register hand-off
  assign move     = item_valid_q && burst_ready_i;
  assign in_i.ready = !item_valid_q || move;
  assign in_fire  = in_i.valid && in_i.ready;
  assign item_valid_d = in_fire ? 1'b1 : (move ? 1'b0 : item_valid_q);

  // length field and checksum terms
  assign total     = {{(LenW-ByteW){1'b0}}, cfg_i.length_overhead} + item_q.payload_len;
  assign hdr_xor   = total[LenW-1:ByteW] ^ total[ByteW-1:0] ^ item_q.command;
  assign data_xor  = xor_q ^ item_q.data_byte;
  assign last_byte = (rem_q == {{(LenW-1){1'b0}}, 1'b1});

  // build the burst and next packet state
  always_comb begin
    burst  = '0;
    burst.err = ErrNone;
    open_d = open_q;
    rem_d  = rem_q;
    xor_d  = xor_q;
    case (item_q.kind)
      KindStart: begin
        burst.bytes[0] = cfg_i.start_marker;
        burst.bytes[1] = total[LenW-1:ByteW];
        burst.bytes[2] = total[ByteW-1:0];
        burst.bytes[3] = item_q.command;
        burst.bytes[4] = hdr_xor;
        burst.err      = open_q ? ErrAbandon : ErrNone;
        xor_d          = hdr_xor;
        rem_d          = item_q.payload_len;
        if (item_q.payload_len == '0) begin
          // empty packet closes at once
          burst.count = CntW'(5);
          burst.chk   = 1'b1;
          open_d      = 1'b0;
        end else begin
          burst.count = CntW'(4);
          open_d      = 1'b1;
        end
      end
      KindPayload: begin
        if (!open_q) begin
          // stray payload byte, state untouched
          burst.count = CntW'(1);
          burst.err   = ErrStray;
        end else begin
          burst.bytes[0] = item_q.data_byte;
          burst.bytes[1] = data_xor;
          xor_d          = data_xor;
          rem_d          = rem_q - {{(LenW-1){1'b0}}, 1'b1};
          burst.count    = last_byte ? CntW'(2) : CntW'(1);
          burst.chk      = last_byte;
          open_d         = !last_byte;
        end
      end
      default: burst = '0;
    endcase
  end

  // control and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      open_q       <= 1'b0;
      rem_q        <= '0;
      xor_q        <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      if (move) begin
        open_q <= open_d;
        rem_q  <= rem_d;
        xor_q  <= xor_d;
      end
    end
  end

  // request payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.kind        <= in_i.kind;
      item_q.command     <= in_i.command;
      item_q.payload_len <= in_i.payload_len;
      item_q.data_byte   <= in_i.data_byte;
    end
  end

  assign burst_valid_o = item_valid_q;
  assign burst_o       = burst;

endmodule

// ----- design/xcpf_tx_burst.sv -----
// ----------------------------------------------------------------------------
// xcpf_tx_burst
// Result register that holds one burst and hands it out a byte at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcpf_tx_burst import xcpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       burst_valid_i,
  output logic       burst_ready_o,
  input  burst_t     burst_i,
  xcpf_out_if.source out_o
);

  burst_t          burst_q;
  logic            valid_q, valid_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            last;
  logic            out_fire;
  logic            load;

  // position in the burst
  assign last          = (idx_q == burst_q.count - CntW'(1));
  assign out_fire      = valid_q && out_o.ready;
  assign burst_ready_o = !valid_q || (out_fire && last);
  assign load          = burst_valid_i && burst_ready_o;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (out_fire) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      burst_q <= burst_i;
    end
  end

  // byte side
  assign out_o.valid          = valid_q;
  assign out_o.tx_byte        = burst_q.bytes[idx_q];
  assign out_o.run_last       = last;
  assign out_o.is_checksum    = last && burst_q.chk;
  assign out_o.protocol_error = burst_q.err;

endmodule

// ----- design/xcpf_checker.sv -----
// ----------------------------------------------------------------------------
// xcpf_checker
// Port-level checks of the packet framer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xcpf_checker import xcpf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] tx_byte_i,
  input logic             run_last_i,
  input logic             is_checksum_i,
  input logic [1:0]       protocol_error_i
);

  logic out_stall;
  logic out_take;
  logic chk_early;
  logic stray_seen;
  logic stray_shape;
  logic err_bad;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_take    = out_valid_i && out_ready_i;
  assign chk_early   = out_valid_i && is_checksum_i && !run_last_i;
  assign stray_seen  = out_valid_i && (protocol_error_i == ErrStray);
  assign stray_shape = run_last_i && !is_checksum_i && (tx_byte_i == '0);
  assign err_bad     = out_valid_i && (protocol_error_i > ErrAbandon);

  // a waiting byte is not withdrawn
  `XCPF_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i)

  // the checksum always closes the burst of its request
  `XCPF_ASSERT_NEVER(a_chk_last, clk_i, rst_ni, chk_early)

  // a stray payload byte gives a single empty result
  `XCPF_ASSERT(a_stray, clk_i, rst_ni, stray_seen |-> stray_shape)

  // no unused error code reaches the port
  `XCPF_ASSERT_NEVER(a_err_code, clk_i, rst_ni, err_bad)

  // a byte taken without closing its burst is followed by another byte
  `XCPF_ASSERT(a_burst_cont, clk_i, rst_ni, (out_take && !run_last_i) |=> out_valid_i)

endmodule

bind xor_checksum_packet_framer xcpf_checker u_xcpf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .tx_byte_i        (out_o.tx_byte),
  .run_last_i       (out_o.run_last),
  .is_checksum_i    (out_o.is_checksum),
  .protocol_error_i (out_o.protocol_error)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR checksum packet framer. Requests go in on
// the request channel, and each accepted request is framed by a predictor in
// the bench into the bytes it must produce. Every byte taken from the output
// channel is compared field by field with the oldest byte still due. Both
// channels idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import xcpf_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // one transmitted byte as the output channel shows it
  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             run_last;
    logic             is_checksum;
    err_e             err;
  } tx_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [ByteW-1:0] cfg_data_i;

  xcpf_in_if  req_if ();
  xcpf_out_if tx_if ();

  xor_checksum_packet_framer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (tx_if)
  );

  // framer copy held by the bench
  cfg_t            framer_cfg;
  logic [LenW-1:0] bytes_left;
  logic [ByteW-1:0] xor_acc;
  logic            pkt_open;
  tx_byte_t        tx_bytes_due[$];

  // idling controls
  bit quiet;
  int gap_pct;
  int stall_pct;
  int long_hold_req;

  // bookkeeping
  int n_fail;
  int n_reqs;
  int n_bytes;
  int n_checksums;
  int n_stray;
  int n_abandon;
  int n_wrap;
  int cycle_count;

  always #5 clk_i = ~clk_i;

  // append one byte to the bytes still due
  function automatic void queue_byte(logic [ByteW-1:0] b, logic last, logic chk, err_e err);
    tx_byte_t e;
    e.tx_byte     = b;
    e.run_last    = last;
    e.is_checksum = chk;
    e.err         = err;
    tx_bytes_due.push_back(e);
  endfunction

  // frame one accepted request into the bytes it must send
  function automatic void frame_request(item_t it);
    err_e            err;
    logic [LenW-1:0] total;
    if (it.kind == KindStart) begin
      err   = pkt_open ? ErrAbandon : ErrNone;
      total = LenW'(framer_cfg.length_overhead) + it.payload_len;
      if ({1'b0, it.payload_len} + 17'(framer_cfg.length_overhead) > 17'hFFFF) n_wrap++;
      if (pkt_open) n_abandon++;
      xor_acc = total[15:8] ^ total[7:0] ^ it.command;
      queue_byte(framer_cfg.start_marker, 1'b0, 1'b0, err);
      queue_byte(total[15:8], 1'b0, 1'b0, err);
      queue_byte(total[7:0], 1'b0, 1'b0, err);
      queue_byte(it.command, it.payload_len != '0, 1'b0, err);
      if (it.payload_len == '0) begin
        queue_byte(xor_acc, 1'b1, 1'b1, err);
        pkt_open   = 1'b0;
        bytes_left = '0;
      end else begin
        pkt_open   = 1'b1;
        bytes_left = it.payload_len;
      end
    end else if (!pkt_open) begin
      // payload with nothing open: error result only, state kept
      n_stray++;
      queue_byte('0, 1'b1, 1'b0, ErrStray);
    end else begin
      xor_acc    = xor_acc ^ it.data_byte;
      bytes_left = bytes_left - 1'b1;
      queue_byte(it.data_byte, bytes_left != '0, 1'b0, ErrNone);
      if (bytes_left == '0) begin
        queue_byte(xor_acc, 1'b1, 1'b1, ErrNone);
        pkt_open = 1'b0;
      end
    end
  endfunction

  function automatic item_t start_req(logic [ByteW-1:0] cmd, logic [LenW-1:0] len);
    item_t it;
    it.kind        = KindStart;
    it.command     = cmd;
    it.payload_len = len;
    it.data_byte   = ByteW'($urandom);
    return it;
  endfunction

  function automatic item_t payload_req(logic [ByteW-1:0] data);
    item_t it;
    it.kind        = KindPayload;
    it.command     = ByteW'($urandom);
    it.payload_len = LenW'($urandom);
    it.data_byte   = data;
    return it;
  endfunction

  // offer one request and wait until it is taken
  task automatic send_req(item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= it.kind;
    req_if.command     <= it.command;
    req_if.payload_len <= it.payload_len;
    req_if.data_byte   <= it.data_byte;
    do @(posedge clk_i); while (!req_if.ready);
    frame_request(it);
    n_reqs++;
  endtask

  // stop offering and let every due byte come out
  task automatic drain();
    req_if.valid <= 1'b0;
    while (tx_bytes_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [ByteW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgStartMarker) framer_cfg.start_marker = val;
    else framer_cfg.length_overhead = val;
    @(posedge clk_i);
  endtask

  // packet: start plus n_payload payload bytes, which may fall short of len
  task automatic send_packet(logic [LenW-1:0] len, int n_payload);
    send_req(start_req(ByteW'($urandom), len));
    repeat (n_payload) send_req(payload_req(ByteW'($urandom)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of both registers, empty packet, short packet, stray byte
  task automatic test_reset_values();
    send_req(payload_req(8'hFF));
    send_req(start_req(8'hA5, 16'd0));
    send_req(start_req(8'h5A, 16'd2));
    send_req(payload_req(8'h81));
    send_req(payload_req(8'h7E));
    drain();
  endtask

  // all-ones and all-zeros bytes and lengths, abandon of a huge packet
  task automatic test_field_extremes();
    write_cfg(CfgStartMarker, 8'hFF);
    write_cfg(CfgLengthOverhead, 8'h00);
    send_req(start_req(8'hFF, 16'd1));
    send_req(payload_req(8'h00));
    send_req(start_req(8'h00, 16'hFFFF));
    send_req(payload_req(8'hFF));
    send_req(start_req(8'h3C, 16'd0));
    send_req(payload_req(8'h00));
    drain();
  endtask

  // length field wrapping past 16 bits with the largest overhead
  task automatic test_length_wrap();
    write_cfg(CfgStartMarker, 8'h00);
    write_cfg(CfgLengthOverhead, 8'hFF);
    send_req(start_req(8'h11, 16'hFFFF));
    send_req(start_req(8'h22, 16'hFF01));
    send_req(start_req(8'h33, 16'd1));
    send_req(payload_req(8'hC3));
    drain();
  endtask

  // a new start drops the open packet
  task automatic test_abandon();
    write_cfg(CfgStartMarker, StartMarkerRst);
    write_cfg(CfgLengthOverhead, LengthOverheadRst);
    send_req(start_req(8'h47, 16'd3));
    send_req(payload_req(8'h01));
    send_req(payload_req(8'h02));
    send_req(start_req(8'h48, 16'd1));
    send_req(payload_req(8'h03));
    drain();
  endtask

  // long output stall while requests keep coming, block must back up
  task automatic test_output_stall();
    gap_pct       = 0;
    stall_pct     = 0;
    long_hold_req = 80;
    send_packet(16'd24, 24);
    drain();
  endtask

  // random packets over several register settings and idling mixes
  task automatic test_random_traffic();
    int sent;
    int r;
    int len;
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      write_cfg(CfgStartMarker, phase == 1 ? 8'hFF : phase == 3 ? 8'h00 : ByteW'($urandom));
      write_cfg(CfgLengthOverhead,
                phase == 2 ? 8'hFF : phase == 4 ? 8'h00 : ByteW'($urandom));
      case (phase)
        0: begin gap_pct = 20; stall_pct = 20; end
        1: begin gap_pct = 0;  stall_pct = 30; end
        2: begin gap_pct = 30; stall_pct = 0;  end
        3: begin gap_pct = 0;  stall_pct = 0;  end
        default: begin gap_pct = 10; stall_pct = 50; end
      endcase
      sent = n_reqs;
      while (n_reqs - sent < 45) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // noise: any field, any kind
          send_req(item_t'({$urandom, $urandom}));
        end else if (r < 14) begin
          // broken packet, cut short and left open
          len = $urandom_range(1, 8);
          send_packet(LenW'(len), $urandom_range(0, len - 1));
        end else begin
          len = (r < 19) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          send_packet(LenW'(len), len);
        end
      end
    end
    drain();
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    quiet = 1'b1;
    repeat (4) send_packet(LenW'($urandom_range(0, 6)), 0);
    send_packet(16'd12, 12);
    send_packet(16'd0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // byte sink with random stalls and one long hold
  // ---------------------------------------------------------------------------
  initial begin : byte_sink
    int stall_left;
    stall_left = 0;
    tx_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req > 0) begin
        stall_left    = long_hold_req;
        long_hold_req = 0;
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        tx_if.ready <= 1'b0;
        stall_left--;
      end else begin
        tx_if.ready <= 1'b1;
      end
    end
  end

  // compare each byte taken with the oldest byte due
  always @(posedge clk_i) begin : byte_check
    tx_byte_t want;
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      n_bytes++;
      if (tx_bytes_due.size() == 0) begin
        $error("unexpected byte %02h with nothing due", tx_if.tx_byte);
        n_fail++;
      end else begin
        want = tx_bytes_due.pop_front();
        if (want.is_checksum) n_checksums++;
        if (tx_if.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_if.tx_byte);
          n_fail++;
        end
        if (tx_if.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, tx_if.run_last);
          n_fail++;
        end
        if (tx_if.is_checksum !== want.is_checksum) begin
          $error("is_checksum: expected %0b, got %0b", want.is_checksum, tx_if.is_checksum);
          n_fail++;
        end
        if (tx_if.protocol_error !== want.err) begin
          $error("protocol_error: expected %0d, got %0d", want.err, tx_if.protocol_error);
          n_fail++;
        end
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cycle limit reached with %0d bytes still due", tx_bytes_due.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    framer_cfg.start_marker    = StartMarkerRst;
    framer_cfg.length_overhead = LengthOverheadRst;
    bytes_left = '0;
    xor_acc    = '0;
    pkt_open   = 1'b0;
    quiet         = 1'b0;
    gap_pct       = 15;
    stall_pct     = 15;
    long_hold_req = 0;
    n_fail = 0; n_reqs = 0; n_bytes = 0; n_checksums = 0;
    n_stray = 0; n_abandon = 0; n_wrap = 0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgStartMarker;
    cfg_data_i         <= '0;
    req_if.valid       <= 1'b0;
    req_if.kind        <= KindStart;
    req_if.command     <= '0;
    req_if.payload_len <= '0;
    req_if.data_byte   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_field_extremes();
    test_length_wrap();
    test_abandon();
    test_output_stall();
    test_random_traffic();
    test_steady_stream();

    // wait out the last bytes, then a few idle cycles
    req_if.valid <= 1'b0;
    waited = 0;
    while (tx_bytes_due.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (tx_bytes_due.size() != 0) begin
      $error("%0d bytes still due at end of run", tx_bytes_due.size());
      n_fail++;
    end

    $display("framed %0d requests into %0d bytes, %0d checksums, %0d cycles",
             n_reqs, n_bytes, n_checksums, cycle_count);
    $display("stray payloads %0d, abandoned packets %0d, wrapped lengths %0d, mismatches %0d",
             n_stray, n_abandon, n_wrap, n_fail);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
